// File: sv/rtt_pkg.sv
`timescale 1ns / 1ps
package rtt_pkg;

  // Fixed widths of the second-moment sum, the root and the step counter.
  localparam int unsigned M2_BITS   = 64;
  localparam int unsigned ROOT_BITS = 32;
  localparam int unsigned STEP_BITS = 6;

  // Divider runs one quotient bit per step over the full M2 width.
  localparam logic [STEP_BITS-1:0] DIV_LAST  = STEP_BITS'(M2_BITS - 1);
  localparam logic [STEP_BITS-1:0] SQRT_LAST = STEP_BITS'(ROOT_BITS - 1);

  typedef enum logic [1:0] {
    CMD_REPLY = 2'd0,
    CMD_LOSS  = 2'd1,
    CMD_CLEAR = 2'd2
  } command_e;

  // Controller to datapath.
  typedef struct packed {
    logic load_in;    // take the input word, update counts, min, max
    logic div_step;   // one restoring divide step by the reply count
    logic mean_upd;   // apply quotient to the mean, load the multiplier
    logic mul_step;   // one shift-add multiply step
    logic m2_add;     // saturating add of the scaled product into M2
    logic sd_load;    // load M2 as dividend
    logic sqrt_init;  // clear root and partial remainder
    logic sqrt_step;  // one root digit
    logic out_load;   // capture the result word
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic div_last;
    logic mul_last;
    logic sqrt_last;
    logic need_sd;
  } dp_sts_t;

endpackage

// File: sv/rtt_datapath.sv
`timescale 1ns / 1ps
module rtt_datapath #(
  parameter int unsigned SAMPLE_BITS    = 24,
  parameter int unsigned COUNT_BITS     = 32,
  parameter int unsigned MEAN_FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  rtt_pkg::dp_cmd_t                      cmd_i,
  output rtt_pkg::dp_sts_t                      sts_o,
  input  logic [1:0]                            command_i,
  input  logic [SAMPLE_BITS-1:0]                sample_us_i,
  output logic [COUNT_BITS-1:0]                 requests_sent_o,
  output logic [COUNT_BITS-1:0]                 replies_received_o,
  output logic [SAMPLE_BITS-1:0]                min_rtt_us_o,
  output logic [SAMPLE_BITS-1:0]                max_rtt_us_o,
  output logic [SAMPLE_BITS+MEAN_FRAC_BITS-1:0] mean_rtt_q16_o,
  output logic [SAMPLE_BITS-1:0]                stddev_rtt_us_o
);
  import rtt_pkg::*;

  localparam int unsigned MW = SAMPLE_BITS + MEAN_FRAC_BITS;
  localparam int unsigned CB = COUNT_BITS;
  localparam int unsigned SB = SAMPLE_BITS;
  localparam logic [STEP_BITS-1:0] MUL_LAST = STEP_BITS'(MW - 1);
  localparam logic [ROOT_BITS-1:0] SD_MAX = ROOT_BITS'((64'd1 << SB) - 64'd1);

  // Statistics state
  logic [CB-1:0]      req_q, req_d, rep_q, rep_d;
  logic [SB-1:0]      min_q, min_d, max_q, max_d, smp_q, smp_d;
  logic [MW-1:0]      mean_q, mean_d, d1_q, d1_d;
  logic [M2_BITS-1:0] m2_q, m2_d;
  logic               up_q, up_d;
  // Work registers
  logic [M2_BITS-1:0]   dvd_q, dvd_d;
  logic [CB-1:0]        rem_q, rem_d;
  logic [2*MW-1:0]      prod_q, prod_d;
  logic [ROOT_BITS+1:0] srem_q, srem_d;
  logic [ROOT_BITS-1:0] root_q, root_d;
  logic [STEP_BITS-1:0] cnt_q, cnt_d;
  // Result word
  logic [CB-1:0] o_req_q, o_req_d, o_rep_q, o_rep_d;
  logic [SB-1:0] o_min_q, o_min_d, o_max_q, o_max_d, o_sd_q, o_sd_d;
  logic [MW-1:0] o_mean_q, o_mean_d;

  logic [MW-1:0]        vq_in, vq_hold, quo, mnew, d2;
  logic [CB:0]          div_r;
  logic [MW:0]          mul_sum;
  logic [M2_BITS-1:0]   add64;
  logic [M2_BITS:0]     m2_sum;
  logic [ROOT_BITS+3:0] sq_r, sq_t;
  logic [SB-1:0]        sd_val;

  always_comb begin
    vq_in   = {sample_us_i, {MEAN_FRAC_BITS{1'b0}}};
    vq_hold = {smp_q, {MEAN_FRAC_BITS{1'b0}}};
    quo     = dvd_q[MW-1:0];
    mnew    = up_q ? mean_q + quo : mean_q - quo;
    d2      = up_q ? vq_hold - mnew : mnew - vq_hold;
    div_r   = {rem_q, dvd_q[M2_BITS-1]};
    mul_sum = {1'b0, prod_q[2*MW-1:MW]} + (prod_q[0] ? {1'b0, d1_q} : '0);
    add64   = M2_BITS'(prod_q >> (2 * MEAN_FRAC_BITS));
    m2_sum  = {1'b0, m2_q} + {1'b0, add64};
    sq_r    = {srem_q, dvd_q[M2_BITS-1:M2_BITS-2]};
    sq_t    = {2'b00, root_q, 2'b01};
    sd_val  = (root_q > SD_MAX) ? '1 : root_q[SB-1:0];
  end

  always_comb begin
    req_d = req_q;   rep_d = rep_q;   min_d = min_q;   max_d = max_q;
    smp_d = smp_q;   mean_d = mean_q; d1_d = d1_q;     m2_d = m2_q;
    up_d = up_q;     dvd_d = dvd_q;   rem_d = rem_q;   prod_d = prod_q;
    srem_d = srem_q; root_d = root_q; cnt_d = cnt_q;
    o_req_d = o_req_q; o_rep_d = o_rep_q; o_min_d = o_min_q;
    o_max_d = o_max_q; o_sd_d = o_sd_q;   o_mean_d = o_mean_q;

    if (cmd_i.load_in) begin
      cnt_d = '0;
      rem_d = '0;
      unique case (command_i)
        CMD_REPLY: begin
          if (rep_q == '0) begin
            min_d = sample_us_i;
            max_d = sample_us_i;
          end else begin
            if (sample_us_i < min_q) min_d = sample_us_i;
            if (sample_us_i > max_q) max_d = sample_us_i;
          end
          req_d = (req_q == '1) ? req_q : req_q + 1'b1;
          rep_d = (rep_q == '1) ? rep_q : rep_q + 1'b1;
          smp_d = sample_us_i;
          up_d  = vq_in >= mean_q;
          d1_d  = (vq_in >= mean_q) ? vq_in - mean_q : mean_q - vq_in;
          dvd_d = M2_BITS'((vq_in >= mean_q) ? vq_in - mean_q : mean_q - vq_in);
        end
        CMD_LOSS: req_d = (req_q == '1) ? req_q : req_q + 1'b1;
        CMD_CLEAR: begin
          req_d = '0; rep_d = '0; min_d = '0; max_d = '0;
          mean_d = '0; m2_d = '0;
        end
        default: ;
      endcase
    end

    if (cmd_i.div_step) begin
      cnt_d = cnt_q + 1'b1;
      if (div_r >= {1'b0, rep_q}) begin
        rem_d = CB'(div_r - {1'b0, rep_q});
        dvd_d = {dvd_q[M2_BITS-2:0], 1'b1};
      end else begin
        rem_d = div_r[CB-1:0];
        dvd_d = {dvd_q[M2_BITS-2:0], 1'b0};
      end
    end

    if (cmd_i.mean_upd) begin
      cnt_d  = '0;
      mean_d = mnew;
      prod_d = {{MW{1'b0}}, d2};
    end

    if (cmd_i.mul_step) begin
      cnt_d  = cnt_q + 1'b1;
      prod_d = {mul_sum, prod_q[MW-1:1]};
    end

    if (cmd_i.m2_add) m2_d = m2_sum[M2_BITS] ? '1 : m2_sum[M2_BITS-1:0];

    if (cmd_i.sd_load) begin
      cnt_d = '0;
      rem_d = '0;
      dvd_d = m2_q;
    end

    if (cmd_i.sqrt_init) begin
      cnt_d  = '0;
      srem_d = '0;
      root_d = '0;
    end

    if (cmd_i.sqrt_step) begin
      cnt_d = cnt_q + 1'b1;
      dvd_d = {dvd_q[M2_BITS-3:0], 2'b00};
      if (sq_r >= sq_t) begin
        srem_d = (ROOT_BITS+2)'(sq_r - sq_t);
        root_d = {root_q[ROOT_BITS-2:0], 1'b1};
      end else begin
        srem_d = sq_r[ROOT_BITS+1:0];
        root_d = {root_q[ROOT_BITS-2:0], 1'b0};
      end
    end

    if (cmd_i.out_load) begin
      o_req_d = req_q;  o_rep_d = rep_q;  o_min_d = min_q;
      o_max_d = max_q;  o_mean_d = mean_q;
      o_sd_d  = sts_o.need_sd ? sd_val : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= '0; rep_q <= '0; min_q <= '0; max_q <= '0;
      mean_q <= '0; m2_q <= '0;
    end else begin
      req_q <= req_d; rep_q <= rep_d; min_q <= min_d; max_q <= max_d;
      mean_q <= mean_d; m2_q <= m2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q <= smp_d;   d1_q <= d1_d;     up_q <= up_d;
    dvd_q <= dvd_d;   rem_q <= rem_d;   prod_q <= prod_d;
    srem_q <= srem_d; root_q <= root_d; cnt_q <= cnt_d;
    o_req_q <= o_req_d; o_rep_q <= o_rep_d; o_min_q <= o_min_d;
    o_max_q <= o_max_d; o_sd_q <= o_sd_d;   o_mean_q <= o_mean_d;
  end

  assign sts_o.div_last  = (cnt_q == DIV_LAST);
  assign sts_o.mul_last  = (cnt_q == MUL_LAST);
  assign sts_o.sqrt_last = (cnt_q == SQRT_LAST);
  assign sts_o.need_sd   = (rep_q > CB'(1)) && (m2_q != '0);

  assign requests_sent_o    = o_req_q;
  assign replies_received_o = o_rep_q;
  assign min_rtt_us_o       = o_min_q;
  assign max_rtt_us_o       = o_max_q;
  assign mean_rtt_q16_o     = o_mean_q;
  assign stddev_rtt_us_o    = o_sd_q;

endmodule

// File: sv/rtt_ctrl.sv
`timescale 1ns / 1ps
module rtt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       command_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rtt_pkg::dp_cmd_t cmd_o,
  input  rtt_pkg::dp_sts_t sts_i
);
  import rtt_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_DIV_MEAN  = 10'b0000000010,
    S_MEAN_UPD  = 10'b0000000100,
    S_MUL       = 10'b0000001000,
    S_M2_ADD    = 10'b0000010000,
    S_CHECK     = 10'b0000100000,
    S_DIV_SD    = 10'b0001000000,
    S_SQRT_INIT = 10'b0010000000,
    S_SQRT      = 10'b0100000000,
    S_DONE      = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;
  logic   accept, out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !ovalid_q || out_ready_i;
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    ovalid_d = ovalid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load_in = 1'b1;
          state_d = (command_i == CMD_REPLY) ? S_DIV_MEAN : S_CHECK;
        end
      end
      S_DIV_MEAN: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_MEAN_UPD;
      end
      S_MEAN_UPD: begin
        cmd_o.mean_upd = 1'b1;
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_last) state_d = S_M2_ADD;
      end
      S_M2_ADD: begin
        cmd_o.m2_add = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.need_sd) begin
          cmd_o.sd_load = 1'b1;
          state_d = S_DIV_SD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV_SD: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_SQRT_INIT;
      end
      S_SQRT_INIT: begin
        cmd_o.sqrt_init = 1'b1;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.sqrt_last) state_d = S_DONE;
      end
      S_DONE: begin
        // hold until the result register is free
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

// File: sv/rtt_running_statistics.sv
`timescale 1ns / 1ps
// Running round-trip statistics. Each input word is a command: reply (counts a
// request and a reply, folds sample_us_i into min, max, a Welford mean with
// MEAN_FRAC_BITS fraction bits and the squared-deviation sum M2), loss (counts
// a request) or clear (restart); code 3 changes nothing. Every input word
// yields exactly one result word with the counts, min, max, mean and the
// population deviation floor(sqrt(floor(M2 / replies))), which reads 0 with
// fewer than two replies or M2 of 0. Counters and M2 saturate. One word is
// processed at a time on a shared 64-step restoring divider, a shift-add
// multiplier of SAMPLE_BITS+MEAN_FRAC_BITS steps and a 32-step digit-by-digit
// square root. A reply is accepted, its deviation from the mean divided by the
// reply count, the mean updated, the product multiplied out and added into
// M2; a loss or clear goes straight to the check. Where a deviation is
// reported, M2 is then divided by the reply count and its root taken, and the
// result is loaded. The result sits in an output register, so the next word
// is taken while a result waits.
module rtt_running_statistics #(
  parameter int unsigned SAMPLE_BITS    = 24,
  parameter int unsigned COUNT_BITS     = 32,
  parameter int unsigned MEAN_FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            command_i,
  input  logic [SAMPLE_BITS-1:0]                sample_us_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [COUNT_BITS-1:0]                 requests_sent_o,
  output logic [COUNT_BITS-1:0]                 replies_received_o,
  output logic [SAMPLE_BITS-1:0]                min_rtt_us_o,
  output logic [SAMPLE_BITS-1:0]                max_rtt_us_o,
  output logic [SAMPLE_BITS+MEAN_FRAC_BITS-1:0] mean_rtt_q16_o,
  output logic [SAMPLE_BITS-1:0]                stddev_rtt_us_o
);
  import rtt_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Sequence the divide, multiply and root steps.
  rtt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (dp_cmd),
    .sts_i       (dp_sts)
  );

  // Hold the statistics and the shared arithmetic registers.
  rtt_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COUNT_BITS     (COUNT_BITS),
    .MEAN_FRAC_BITS (MEAN_FRAC_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (dp_cmd),
    .sts_o              (dp_sts),
    .command_i          (command_i),
    .sample_us_i        (sample_us_i),
    .requests_sent_o    (requests_sent_o),
    .replies_received_o (replies_received_o),
    .min_rtt_us_o       (min_rtt_us_o),
    .max_rtt_us_o       (max_rtt_us_o),
    .mean_rtt_q16_o     (mean_rtt_q16_o),
    .stddev_rtt_us_o    (stddev_rtt_us_o)
  );

`ifndef SYNTHESIS
  // An accepted word leaves the block busy in the cycle after it is taken.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken on consecutive cycles");

  // Replies never outnumber requests.
  a_rep_le_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> replies_received_o <= requests_sent_o)
    else $error("reply count above request count");

  // Min never exceeds max once a reply was seen.
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && replies_received_o != '0 |-> min_rtt_us_o <= max_rtt_us_o)
    else $error("min above max");

  // Deviation reads zero with fewer than two replies.
  a_sd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && replies_received_o < COUNT_BITS'(2) |-> stddev_rtt_us_o == '0)
    else $error("deviation with fewer than two replies");
`endif

endmodule
